### rtl/core/ssr_pkg.sv
`default_nettype none

package ssr_pkg;

    // window and byte geometry
    localparam int BYTE_W    = 8;
    localparam int WINDOW    = 8;
    localparam int HELD_W    = $clog2(WINDOW);
    localparam int LEN_W     = 4;
    localparam int RUN_CNT_W = $clog2(WINDOW + 1);
    localparam int REG_W     = WINDOW * BYTE_W;
    localparam int REG_IDX_W = 2;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    // register indexes of the configuration port
    localparam reg_idx_t REG_PATTERN_BYTES      = 2'd0;
    localparam reg_idx_t REG_PATTERN_LENGTH     = 2'd1;
    localparam reg_idx_t REG_REPLACEMENT_BYTES  = 2'd2;
    localparam reg_idx_t REG_REPLACEMENT_LENGTH = 2'd3;

    // window shift amounts
    typedef enum logic [1:0] {
        SHIFT_NONE = 2'd0,
        SHIFT_ONE  = 2'd1,
        SHIFT_TWO  = 2'd2
    } shift_t;

    typedef logic [WINDOW-1:0][BYTE_W-1:0] byte_vec_t;

    // control shared by every window cell
    typedef struct packed {
        logic   advance;
        shift_t shift;
    } cell_ctl_t;

    // run of output words produced by one text word
    typedef struct packed {
        byte_vec_t             bytes;
        logic [RUN_CNT_W-1:0]  cnt;
        logic                  eot;
    } run_t;

endpackage

`default_nettype wire

### rtl/core/ssr_if.sv
`default_nettype none

// text channel
interface ssr_in_if;
    import ssr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

// rewritten text channel
interface ssr_out_if;
    import ssr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic              text_done;

    modport source (output valid, output out_byte, output last_of_run,
                    output text_done, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input text_done, output ready);
endinterface

`default_nettype wire

### rtl/core/ssr_cell.sv
`default_nettype none

module ssr_cell (
    input  wire logic                     clk,
    input  wire ssr_pkg::cell_ctl_t       ctl,
    input  wire logic                     occupied,
    input  wire logic [ssr_pkg::BYTE_W-1:0] new_byte,
    input  wire logic [ssr_pkg::BYTE_W-1:0] pat_byte,
    input  wire logic [ssr_pkg::BYTE_W-1:0] next1_byte,
    input  wire logic [ssr_pkg::BYTE_W-1:0] next2_byte,
    output logic [ssr_pkg::BYTE_W-1:0]      win_byte,
    output logic                            match
);
    import ssr_pkg::*;

    logic [BYTE_W-1:0] held_reg;
    logic [BYTE_W-1:0] held_next;

    // window byte: held byte, or the incoming word in any free slot
    assign win_byte = occupied ? held_reg : new_byte;
    assign match    = (win_byte == pat_byte);

    // take a byte from self or a neighbor when the window moves
    always_comb
    begin
        held_next = held_reg;
        if (ctl.advance)
        begin
            case (ctl.shift)
                SHIFT_NONE: held_next = win_byte;
                SHIFT_ONE:  held_next = next1_byte;
                SHIFT_TWO:  held_next = next2_byte;
                default:    held_next = win_byte;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

`default_nettype wire

### rtl/core/ssr_emit.sv
`default_nettype none

module ssr_emit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire ssr_pkg::run_t run,
    output logic               space,
    ssr_out_if.source          result
);
    import ssr_pkg::*;

    byte_vec_t            data_reg;
    byte_vec_t            data_next;
    logic [RUN_CNT_W-1:0] cnt_reg;
    logic [RUN_CNT_W-1:0] cnt_next;
    logic                 eot_reg;
    logic                 eot_next;
    logic                 take;

    assign take = result.valid && result.ready;

    // room for a new run once the current one is gone or leaves this cycle
    assign space = (cnt_reg == '0) ||
                   ((cnt_reg == RUN_CNT_W'(1)) && result.ready);

    assign result.valid       = (cnt_reg != '0);
    assign result.out_byte    = data_reg[0];
    assign result.last_of_run = (cnt_reg == RUN_CNT_W'(1));
    assign result.text_done   = (cnt_reg == RUN_CNT_W'(1)) && eot_reg;

    // load a run or move the queue one word toward the port
    always_comb
    begin
        data_next = data_reg;
        cnt_next  = cnt_reg;
        eot_next  = eot_reg;
        if (load)
        begin
            data_next = run.bytes;
            cnt_next  = run.cnt;
            eot_next  = run.eot;
        end
        else if (take)
        begin
            for (int i = 0; i < WINDOW - 1; i++)
            begin
                data_next[i] = data_reg[i+1];
            end
            data_next[WINDOW-1] = data_reg[WINDOW-1];
            cnt_next            = cnt_reg - RUN_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            eot_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            eot_reg <= eot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

### rtl/core/stream_substring_replace_core.sv
`default_nettype none

// Stream substring replacer.
// text carries one byte of input text per word (in_byte, end_of_text);
// rewritten carries one output byte per word (out_byte, last_of_run,
// text_done). Registers are written through cfg_write / cfg_index /
// cfg_data: 0 pattern bytes, 1 pattern length, 2 replacement bytes,
// 3 replacement length. Write them only while the block is idle.
// A text word is matched in the cycle it is accepted against a row of
// eight window cells; its output bytes (0 to 8) appear from the next
// cycle on, one per cycle while the receiver is ready. A text word is
// taken every cycle while the output run buffer is empty or holds its
// last byte and that byte leaves; a word that makes output bytes holds
// the text channel until its last byte leaves the single output port.
// Words that make no output do not hold the text channel.
// When the receiver stalls, the run buffer holds and text.ready drops.
// Reset empties the hold and the run buffer, clears both byte registers
// and sets both lengths to one.
module stream_substring_replace_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire ssr_pkg::reg_idx_t         cfg_index,
    input  wire logic [ssr_pkg::REG_W-1:0] cfg_data,
    ssr_in_if.sink                         text,
    ssr_out_if.source                      rewritten
);
    import ssr_pkg::*;

    // configuration registers
    logic [REG_W-1:0] pat_bytes_reg;
    logic [LEN_W-1:0] pat_len_reg;
    logic [REG_W-1:0] rep_bytes_reg;
    logic [LEN_W-1:0] rep_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= LEN_W'(1);
            rep_bytes_reg <= '0;
            rep_len_reg   <= LEN_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PATTERN_BYTES:      pat_bytes_reg <= cfg_data;
                REG_PATTERN_LENGTH:     pat_len_reg   <= cfg_data[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  rep_bytes_reg <= cfg_data;
                REG_REPLACEMENT_LENGTH: rep_len_reg   <= cfg_data[LEN_W-1:0];
                default:                ;
            endcase
        end
    end

    // effective lengths
    logic [LEN_W-1:0] plen;
    logic [LEN_W-1:0] rlen;

    always_comb
    begin
        if (pat_len_reg == '0)
            plen = LEN_W'(1);
        else if (pat_len_reg > LEN_W'(WINDOW))
            plen = LEN_W'(WINDOW);
        else
            plen = pat_len_reg;
        rlen = (rep_len_reg > LEN_W'(WINDOW)) ? LEN_W'(WINDOW) : rep_len_reg;
    end

    // hold count and window cells
    logic [HELD_W-1:0] held_cnt_reg;
    logic [HELD_W-1:0] held_cnt_next;
    logic              accept;
    logic              space;
    cell_ctl_t         ctl;
    byte_vec_t         win;
    logic [WINDOW-1:0] match;
    logic [WINDOW-1:0] occupied;
    logic [WINDOW-1:0] in_pattern;

    assign text.ready = space;
    assign accept     = text.valid && space;

    genvar g;
    generate
        for (g = 0; g < WINDOW; g++)
        begin : g_cell
            logic [BYTE_W-1:0] next1;
            logic [BYTE_W-1:0] next2;

            if (g + 1 < WINDOW)
            begin : g_n1
                assign next1 = win[g+1];
            end
            else
            begin : g_n1z
                assign next1 = '0;
            end

            if (g + 2 < WINDOW)
            begin : g_n2
                assign next2 = win[g+2];
            end
            else
            begin : g_n2z
                assign next2 = '0;
            end

            assign occupied[g]   = (HELD_W'(g) < held_cnt_reg);
            assign in_pattern[g] = (LEN_W'(g) < plen);

            ssr_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .occupied   (occupied[g]),
                .new_byte   (text.in_byte),
                .pat_byte   (pat_bytes_reg[g*BYTE_W +: BYTE_W]),
                .next1_byte (next1),
                .next2_byte (next2),
                .win_byte   (win[g]),
                .match      (match[g])
            );
        end
    endgenerate

    // match decision and run assembly
    logic [LEN_W-1:0] n;
    logic [LEN_W-1:0] start;
    logic [LEN_W-1:0] keep;
    logic             drain;
    logic             full;
    logic             hit;
    run_t             run;

    always_comb
    begin
        n     = LEN_W'(held_cnt_reg) + LEN_W'(1);
        drain = (LEN_W'(held_cnt_reg) >= plen);
        full  = !drain && (n == plen);
        hit   = full && (&(match | ~in_pattern));

        if (drain)
            start = LEN_W'(2);
        else if (hit)
            start = n;
        else if (full)
            start = LEN_W'(1);
        else
            start = '0;
        keep = text.end_of_text ? '0 : (n - start);

        ctl.advance = accept;
        if (drain)
            ctl.shift = SHIFT_TWO;
        else if (full)
            ctl.shift = SHIFT_ONE;
        else
            ctl.shift = SHIFT_NONE;

        held_cnt_next = accept ? keep[HELD_W-1:0] : held_cnt_reg;

        run.bytes = hit ? rep_bytes_reg : win;
        if (hit)
            run.cnt = RUN_CNT_W'(rlen);
        else if (text.end_of_text)
            run.cnt = RUN_CNT_W'(n);
        else
            run.cnt = RUN_CNT_W'(start);
        run.eot = text.end_of_text;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_cnt_reg <= '0;
        else
            held_cnt_reg <= held_cnt_next;
    end

    // output run buffer
    ssr_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .run    (run),
        .space  (space),
        .result (rewritten)
    );

endmodule

`default_nettype wire
